### rtl/core/assert_macros.svh
// Assertion macros shared by the peak finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

### rtl/core/wzh_pkg.sv
// Types and constants shared by the weighted z histogram peak finder.
`default_nettype none

package wzh_pkg;

    localparam int Z_W       = 16;
    localparam int PT_W      = 20;
    localparam int ETA_W     = 14;
    localparam int LOG2_W    = 5;
    localparam int LIMIT_W   = 13;
    localparam int SUM_W     = 32;
    localparam int BIN_OUT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;
    localparam int TAG_W     = 8;

    // Histogram covers z0 in [-30000, 30000) hundredths of a millimetre.
    localparam logic signed [Z_W:0] Z_HALF = 17'sd30000;

    // off * 2^L / 60000 = (off << (L-5)) / 1875. With a reciprocal rounded up
    // to 38 fractional bits the quotient is exact for every numerator below 2^27.
    localparam int RECIP_W          = 28;
    localparam int RECIP_FRAC       = 38;
    localparam int RECIP_SHIFT_BASE = RECIP_FRAC + 5;
    localparam logic [RECIP_W-1:0] Z_RECIP =
        RECIP_W'(((64'd1 << RECIP_FRAC) + 64'd1874) / 64'd1875);

    localparam logic [LOG2_W-1:0] LOG2_MIN = 5'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_ENABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PT_MINIMUM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA_LIMIT  = 2'd3;

    localparam logic [LOG2_W-1:0]  RST_BINS_LOG2  = 5'd8;
    localparam logic [PT_W-1:0]    RST_PT_MINIMUM = 20'd1000;
    localparam logic [LIMIT_W-1:0] RST_ETA_LIMIT  = 13'd3072;

    typedef struct packed {
        logic [LOG2_W-1:0]  bins_log2;
        logic               cut_enable;
        logic [PT_W-1:0]    pt_minimum;
        logic [LIMIT_W-1:0] eta_limit;
    } t_track_cfg;

endpackage

`default_nettype wire

### rtl/core/weighted_z_histogram_peak_finder.sv
// Top level of the weighted z histogram peak finder: configuration registers and the pipeline.
//
// Tracks arrive on the input channel (i_valid / o_stall), one word per track; a word
// with i_event_end set closes the event, and i_track_present may be low on that word.
// Each closing word yields one result word on the output channel (o_valid / i_stall):
// the lowest bin index holding the greatest pt sum, and that sum (both zero for an
// empty event). Registers are written on the configuration channel (i_cfg_valid /
// o_cfg_ready, always ready); the user must write them only while no event is in flight;
// the block does not enforce this. The front end takes one word per cycle while o_stall
// is low, into a two-stage pipeline and a four-word queue; the histogram engine reads the
// bin of each accepted track in its idle state and writes it back in its update state, and
// closes an event in its emit state. A closing word passes the r1 and r2 registers and the
// queue, then the engine's read and update states if it carries an accepted track, and its
// emit state before o_valid rises.
// After reset the bin memory is swept, one entry per cycle over all of its entries, with
// o_stall held high; the same sweep repeats once every 256 events.
// When the receiver stalls, the result is held in the output register; the engine
// stops at the next closing word and the input stalls once the queue is full.
`default_nettype none

module weighted_z_histogram_peak_finder #(
    parameter int MAX_BINS = 65536
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [wzh_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [wzh_pkg::CFG_DAT_W-1:0]          i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [wzh_pkg::Z_W-1:0]         i_track_z0,
    input  logic        [wzh_pkg::PT_W-1:0]        i_track_pt,
    input  logic signed [wzh_pkg::ETA_W-1:0]       i_track_eta,
    input  logic                                   i_track_present,
    input  logic                                   i_event_end,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [wzh_pkg::BIN_OUT_W-1:0]          o_peak_bin,
    output logic [wzh_pkg::SUM_W-1:0]              o_peak_sum
);
    import wzh_pkg::*;

    localparam int BIN_W = $clog2(MAX_BINS + 1) - 1;
    localparam int JOB_W = BIN_W + PT_W + 2;

    t_track_cfg        r_cfg;
    logic              clearing;
    logic              q_push;
    logic [JOB_W-1:0]  q_in;
    logic              q_ready;
    logic              q_valid;
    logic [JOB_W-1:0]  q_out;
    logic              q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bins_log2  <= RST_BINS_LOG2;
            r_cfg.cut_enable <= 1'b0;
            r_cfg.pt_minimum <= RST_PT_MINIMUM;
            r_cfg.eta_limit  <= RST_ETA_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BINS_LOG2:  r_cfg.bins_log2  <= i_cfg_data[LOG2_W-1:0];
                CFG_CUT_ENABLE: r_cfg.cut_enable <= i_cfg_data[0];
                CFG_PT_MINIMUM: r_cfg.pt_minimum <= i_cfg_data[PT_W-1:0];
                CFG_ETA_LIMIT:  r_cfg.eta_limit  <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wzh_front #(
        .BIN_W (BIN_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_hold          (clearing),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_track_z0      (i_track_z0),
        .i_track_pt      (i_track_pt),
        .i_track_eta     (i_track_eta),
        .i_track_present (i_track_present),
        .i_event_end     (i_event_end),
        .o_push          (q_push),
        .o_job           (q_in),
        .i_q_ready       (q_ready)
    );

    wzh_queue #(
        .WIDTH (JOB_W),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    wzh_back #(
        .BIN_W (BIN_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_out),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_peak_bin (o_peak_bin),
        .o_peak_sum (o_peak_sum)
    );

endmodule

`default_nettype wire

### rtl/core/wzh_front.sv
// Front end: takes tracks, applies the cuts and range check, and works out the bin index.
`default_nettype none

module wzh_front #(
    parameter int BIN_W = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  wzh_pkg::t_track_cfg                  i_cfg,
    input  logic                                 i_hold,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [wzh_pkg::Z_W-1:0]       i_track_z0,
    input  logic        [wzh_pkg::PT_W-1:0]      i_track_pt,
    input  logic signed [wzh_pkg::ETA_W-1:0]     i_track_eta,
    input  logic                                 i_track_present,
    input  logic                                 i_event_end,
    output logic                                 o_push,
    output logic [BIN_W+wzh_pkg::PT_W+1:0]       o_job,
    input  logic                                 i_q_ready
);
    import wzh_pkg::*;

    localparam int PROD_W = Z_W + RECIP_W;
    localparam int IDX_LSB = RECIP_SHIFT_BASE - BIN_W;
    localparam logic [LOG2_W-1:0] BIN_W_V = LOG2_W'(BIN_W);

    logic signed [Z_W:0]   z_ext;
    logic [Z_W:0]          off_sum;
    logic                  in_range;
    logic [ETA_W-1:0]      eta_raw;
    logic [ETA_W-1:0]      eta_mag;
    logic                  cut_fail;
    logic                  keep;
    logic [LOG2_W-1:0]     b_eff;
    logic                  accept;
    logic                  r2_need;
    logic                  adv2;
    logic [BIN_W-1:0]      idx_full;
    logic [BIN_W-1:0]      idx;

    logic                  r1_valid;
    logic                  r1_keep;
    logic                  r1_end;
    logic [Z_W-1:0]        r1_off;
    logic [PT_W-1:0]       r1_pt;
    logic [LOG2_W-1:0]     r1_shift;

    logic                  r2_valid;
    logic                  r2_keep;
    logic                  r2_end;
    logic [PT_W-1:0]       r2_pt;
    logic [LOG2_W-1:0]     r2_shift;
    logic [PROD_W-1:0]     r2_prod;

    assign z_ext    = {i_track_z0[Z_W-1], i_track_z0};
    assign in_range = (z_ext >= -Z_HALF) && (z_ext < Z_HALF);
    assign off_sum  = unsigned'(z_ext + Z_HALF);

    // The magnitude of the most negative eta still fits, as 8192.
    assign eta_raw  = unsigned'(i_track_eta);
    assign eta_mag  = eta_raw[ETA_W-1] ? (~eta_raw + ETA_W'(1)) : eta_raw;
    assign cut_fail = i_cfg.cut_enable &&
                      ((i_track_pt < i_cfg.pt_minimum) ||
                       (eta_mag > ETA_W'(i_cfg.eta_limit)));
    assign keep     = i_track_present && in_range && !cut_fail;

    always_comb begin
        if (i_cfg.bins_log2 < LOG2_MIN) begin
            b_eff = LOG2_MIN;
        end else if (i_cfg.bins_log2 > BIN_W_V) begin
            b_eff = BIN_W_V;
        end else begin
            b_eff = i_cfg.bins_log2;
        end
    end

    // Words that neither hit a bin nor end the event go no further.
    assign r2_need = r2_keep || r2_end;
    assign adv2    = !r2_valid || !r2_need || i_q_ready;
    assign o_stall = i_hold || (r1_valid && !adv2);
    assign accept  = i_valid && !o_stall;

    assign idx_full = r2_prod[IDX_LSB +: BIN_W];
    assign idx      = idx_full >> r2_shift;
    assign o_push   = r2_valid && r2_need && i_q_ready;
    assign o_job    = {r2_keep, r2_end, r2_pt, idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r1_valid <= 1'b1;
            end else if (adv2) begin
                r1_valid <= 1'b0;
            end
            if (adv2) begin
                r2_valid <= r1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_keep  <= keep;
            r1_end   <= i_event_end;
            r1_off   <= off_sum[Z_W-1:0];
            r1_pt    <= i_track_pt;
            r1_shift <= BIN_W_V - b_eff;
        end
        if (adv2 && r1_valid) begin
            r2_keep  <= r1_keep;
            r2_end   <= r1_end;
            r2_pt    <= r1_pt;
            r2_shift <= r1_shift;
            r2_prod  <= PROD_W'(r1_off) * PROD_W'(Z_RECIP);
        end
    end

endmodule

`default_nettype wire

### rtl/core/wzh_queue.sv
// Short queue of bin jobs between the front end and the histogram engine.
`default_nettype none
`include "assert_macros.svh"

module wzh_queue #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W:0] DEPTH_V = (PTR_W+1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_slots [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != DEPTH_V);
    assign o_valid = (r_count != '0);
    assign o_data  = r_slots[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && !o_ready, "queue written while full")

endmodule

`default_nettype wire

### rtl/core/wzh_back.sv
// Histogram engine: bin read-modify-write, running peak, result register and clear sweep.
`default_nettype none
`include "assert_macros.svh"

module wzh_back #(
    parameter int BIN_W = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  logic [BIN_W+wzh_pkg::PT_W+1:0]      i_q_data,
    output logic                                o_pop,
    output logic                                o_clearing,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [wzh_pkg::BIN_OUT_W-1:0]       o_peak_bin,
    output logic [wzh_pkg::SUM_W-1:0]           o_peak_sum
);
    import wzh_pkg::*;

    localparam int JOB_W = BIN_W + PT_W + 2;
    localparam int DEPTH = 2 ** BIN_W;
    localparam int MEM_W = TAG_W + SUM_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_UPD   = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [MEM_W-1:0]  r_mem [0:DEPTH-1];
    logic [MEM_W-1:0]  r_rd_data;

    logic [1:0]        r_state;
    logic [BIN_W-1:0]  r_clr_addr;
    logic [TAG_W-1:0]  r_epoch;
    logic [BIN_W-1:0]  r_best_bin;
    logic [SUM_W-1:0]  r_best_sum;
    logic              r_out_valid;
    logic [BIN_OUT_W-1:0] r_out_bin;
    logic [SUM_W-1:0]  r_out_sum;
    logic [BIN_W-1:0]  r_job_idx;
    logic [PT_W-1:0]   r_job_pt;
    logic              r_job_end;

    logic              head_keep;
    logic              head_end;
    logic [PT_W-1:0]   head_pt;
    logic [BIN_W-1:0]  head_idx;
    logic              mem_re;
    logic              mem_we;
    logic [BIN_W-1:0]  mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic [SUM_W-1:0]  old_sum;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  new_sum;
    logic              better;
    logic              out_free;
    logic              emit;

    assign head_keep = i_q_data[JOB_W-1];
    assign head_end  = i_q_data[JOB_W-2];
    assign head_pt   = i_q_data[BIN_W +: PT_W];
    assign head_idx  = i_q_data[BIN_W-1:0];

    assign o_pop  = (r_state == S_IDLE) && i_q_valid;
    assign mem_re = o_pop && head_keep;

    // An entry whose tag is from an earlier event counts as empty.
    assign old_sum = (r_rd_data[MEM_W-1 -: TAG_W] == r_epoch) ? r_rd_data[SUM_W-1:0] : '0;
    assign sum_ext = {1'b0, old_sum} + (SUM_W+1)'(r_job_pt);
    assign new_sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    assign better  = (new_sum > r_best_sum) ||
                     ((new_sum == r_best_sum) && (r_job_idx < r_best_bin));

    assign mem_we    = (r_state == S_UPD) || (r_state == S_CLEAR);
    assign mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_job_idx;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 : {r_epoch, new_sum};

    assign out_free = !r_out_valid || !i_stall;
    assign emit     = (r_state == S_EMIT) && out_free;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_peak_bin = r_out_bin;
    assign o_peak_sum = r_out_sum;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[head_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_epoch     <= '0;
            r_best_bin  <= '0;
            r_best_sum  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + BIN_W'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= head_keep ? S_UPD : S_EMIT;
                    end
                end
                S_UPD: begin
                    if (better) begin
                        r_best_sum <= new_sum;
                        r_best_bin <= r_job_idx;
                    end
                    r_state <= r_job_end ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_best_sum <= '0;
                        r_best_bin <= '0;
                        // Once the tag space is used up, the whole store is swept again.
                        if (r_epoch == '1) begin
                            r_epoch    <= '0;
                            r_clr_addr <= '0;
                            r_state    <= S_CLEAR;
                        end else begin
                            r_epoch <= r_epoch + TAG_W'(1);
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job_idx <= head_idx;
            r_job_pt  <= head_pt;
            r_job_end <= head_end;
        end
        if (emit) begin
            r_out_bin <= BIN_OUT_W'(r_best_bin);
            r_out_sum <= r_best_sum;
        end
    end

    `ASSERT_CLK(a_upd_follows_read, i_clk, i_rst_n, (r_state == S_UPD) |-> ($past(r_state) == S_IDLE), "bin update without a preceding read")
    `ASSERT_CLK(a_result_from_emit, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_EMIT), "result loaded outside the emit state")

endmodule

`default_nettype wire
